// ===== rtl/core/tkri_pkg.sv =====
// ============================================================================
// Ranked insert table package
// Shared sizes, request codes, row and placement types, and the rank compare.
// ============================================================================
package tkri_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    localparam int SCORE_W  = 32;
    localparam int DEPTH_W  = 8;
    localparam int TURNS_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int RIDX_W   = 4;
    localparam int RANK_W   = 4;
    localparam int ECNT_W   = 5;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [DEPTH_W-1:0]  depth;
        logic [TURNS_W-1:0]  turns;
        logic [HANDLE_W-1:0] handle;
    } row_t;

    typedef struct packed {
        logic             placed;
        logic [CNT_W-1:0] pos;
    } place_t;

    // True if record a ranks strictly above record b.
    function automatic logic ranks_above(input row_t a, input row_t b);
        logic result;
        if (a.score != b.score) begin
            result = (a.score > b.score);
        end else if (a.depth != b.depth) begin
            result = (a.depth > b.depth);
        end else begin
            result = (a.turns < b.turns);
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/tkri_place.sv =====
// ============================================================================
// Ranked insert position finder
// Compares a new record against every valid row in parallel and returns the
// first row it ranks above, or the entry count, and whether it fits.
// ============================================================================
module tkri_place (
    input  tkri_pkg::row_t                 rows [tkri_pkg::TABLE_SIZE],
    input  logic [tkri_pkg::CNT_W-1:0]     count,
    input  tkri_pkg::row_t                 new_row,
    output tkri_pkg::place_t               place
);
    import tkri_pkg::*;

    logic [TABLE_SIZE-1:0] hit;
    logic [CNT_W-1:0]      pos;

    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            hit[i] = (CNT_W'(i) < count) && ranks_above(new_row, rows[i]);
        end
    end

    always_comb
    begin
        pos = count;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                pos = CNT_W'(i);
            end
        end
    end

    assign place.pos    = pos;
    assign place.placed = (pos < CNT_W'(TABLE_SIZE));

endmodule

// ===== rtl/core/top_k_ranked_insert.sv =====
// ============================================================================
// Top-k ranked insert table
// Keeps up to sixteen records sorted by score, depth and turns; handles
// insert, row read and clear requests with one result per request.
// ============================================================================
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: record and read index, tuser: request
// m_*       out  m_tvalid/m_tready   tdata: rank, row, count, tuser: flags
//
// For each request the parallel compare and the one-step shift
// update the table at the accepting edge, and the result is registered.
// A new transaction is accepted every cycle while the result register is
// empty or being drained; a stalled output holds the input.
// Reset empties the table; row contents are not cleared.
//
module top_k_ranked_insert (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // new_score, new_depth, new_turns, new_handle, read_index, zero pad
    input  logic [tkri_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type
    input  logic [tkri_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rank, row_score, row_depth, row_turns, row_handle, entry_count, zero pad
    output logic [tkri_pkg::M_TDATA_W-1:0]      m_tdata,
    // placed, row_valid
    output logic [tkri_pkg::M_TUSER_W-1:0]      m_tuser
);
    import tkri_pkg::*;

    row_t              rows_reg [TABLE_SIZE];
    row_t              rows_next [TABLE_SIZE];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              placed_reg;
    logic              placed_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              row_valid_reg;
    logic              row_valid_next;
    row_t              row_out_reg;
    row_t              row_out_next;

    row_t              new_row;
    logic [RIDX_W-1:0] read_index;
    req_t              req;
    place_t            place;
    logic              accept;

    assign new_row.score  = s_tdata[31:0];
    assign new_row.depth  = s_tdata[39:32];
    assign new_row.turns  = s_tdata[71:40];
    assign new_row.handle = s_tdata[87:72];
    assign read_index     = s_tdata[91:88];
    assign req            = req_t'(s_tuser);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tkri_place u_place (
        .rows    (rows_reg),
        .count   (count_reg),
        .new_row (new_row),
        .place   (place)
    );

    always_comb
    begin
        rows_next      = rows_reg;
        count_next     = count_reg;
        placed_next    = 1'b0;
        rank_next      = '0;
        row_valid_next = 1'b0;
        row_out_next   = '0;
        case (req)
            REQ_INSERT:
            begin
                if (place.placed)
                begin
                    for (int i = 0; i < TABLE_SIZE; i++)
                    begin
                        if (CNT_W'(i) == place.pos)
                        begin
                            rows_next[i] = new_row;
                        end
                        else if ((i > 0) && (CNT_W'(i) > place.pos))
                        begin
                            rows_next[i] = rows_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    if (count_reg < CNT_W'(TABLE_SIZE))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    placed_next = 1'b1;
                    rank_next   = RANK_W'(place.pos);
                end
            end
            REQ_READ:
            begin
                if (int'(read_index) < int'(count_reg))
                begin
                    row_valid_next = 1'b1;
                    row_out_next   = rows_reg[IDX_W'(read_index)];
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rows_reg      <= rows_next;
            placed_reg    <= placed_next;
            rank_reg      <= rank_next;
            row_valid_reg <= row_valid_next;
            row_out_reg   <= row_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {row_valid_reg, placed_reg};
    assign m_tdata  = {7'd0, ECNT_W'(count_reg), row_out_reg.handle, row_out_reg.turns,
                       row_out_reg.depth, row_out_reg.score, rank_reg};

endmodule

// ===== rtl/core/tkri_checker.sv =====
// ============================================================================
// Ranked insert port checker
// Watches the ports of the top level and flags results that break the
// table's invariants; bound to every instance of the top level.
// ============================================================================
module tkri_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [tkri_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic [tkri_pkg::S_TUSER_W-1:0]    s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tkri_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [tkri_pkg::M_TUSER_W-1:0]    m_tuser
);
    import tkri_pkg::*;

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[96:92] <= 5'(TABLE_SIZE))
        else $error("entry count above table size");

    // A result is never both a placement and a row read.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("placed and row valid both set");

    // A placed record lies inside the valid rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> {1'b0, m_tdata[3:0]} < m_tdata[96:92])
        else $error("rank outside the valid rows");

    // A placed result whose count is below the table size shows a non-empty table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[0] && (m_tdata[96:92] != 5'(TABLE_SIZE))
        |-> m_tdata[96:92] != 5'd0)
        else $error("placed insert left the table empty");

endmodule

bind top_k_ranked_insert tkri_checker u_tkri_checker (.*);

// ===== test/tb_top_k_ranked_insert.sv =====
// ============================================================================
// Ranked insert table testbench
// Drives insert, read, clear and unknown requests through the slave stream
// with random stalls on both sides. An in-order shadow of the ranked table
// predicts every result, and the monitor compares each output transaction
// field by field against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_top_k_ranked_insert;

    import tkri_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         RANDOM_ITEMS = 1750;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         CALM_START   = 1000;
    localparam int         CALM_END     = 1600;

    localparam int OFS_SCORE  = RANK_W;
    localparam int OFS_DEPTH  = OFS_SCORE + SCORE_W;
    localparam int OFS_TURNS  = OFS_DEPTH + DEPTH_W;
    localparam int OFS_HANDLE = OFS_TURNS + TURNS_W;
    localparam int OFS_COUNT  = OFS_HANDLE + HANDLE_W;

    typedef struct {
        logic [1:0]          req;
        logic [SCORE_W-1:0]  score;
        logic [DEPTH_W-1:0]  depth;
        logic [TURNS_W-1:0]  turns;
        logic [HANDLE_W-1:0] handle;
        logic [RIDX_W-1:0]   idx;
    } request_t;

    typedef struct {
        logic                placed;
        logic [RANK_W-1:0]   rank;
        logic                row_valid;
        logic [SCORE_W-1:0]  score;
        logic [DEPTH_W-1:0]  depth;
        logic [TURNS_W-1:0]  turns;
        logic [HANDLE_W-1:0] handle;
        logic [ECNT_W-1:0]   count;
    } response_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    request_t  pending_q[$];
    response_t response_q[$];
    request_t  cur_req;
    response_t want;
    response_t got;
    row_t      shadow_rows[TABLE_SIZE];
    int        shadow_count = 0;
    int        total_requests = 0;
    int        accepted_requests = 0;
    int        errors = 0;
    int        cycle_count = 0;

    top_k_ranked_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit take_idle();
        if (cycle_count >= CALM_START && cycle_count < CALM_END)
        begin
            return 1'b0;
        end
        return ($urandom_range(0, 99) < 26);
    endfunction

    function automatic bit outranks(input row_t a, input row_t b);
        if (a.score != b.score)
        begin
            return a.score > b.score;
        end
        if (a.depth != b.depth)
        begin
            return a.depth > b.depth;
        end
        return a.turns < b.turns;
    endfunction

    task automatic rank_request(input request_t rq, output response_t rs);
        row_t rec;
        int   pos;
        int   last;
        rs = '{default: '0};
        rec.score  = rq.score;
        rec.depth  = rq.depth;
        rec.turns  = rq.turns;
        rec.handle = rq.handle;
        case (rq.req)
            REQ_INSERT:
            begin
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (outranks(rec, shadow_rows[i]))
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos < TABLE_SIZE)
                begin
                    last = (shadow_count < TABLE_SIZE) ? shadow_count : TABLE_SIZE - 1;
                    for (int i = last; i > pos; i--)
                    begin
                        shadow_rows[i] = shadow_rows[i-1];
                    end
                    shadow_rows[pos] = rec;
                    if (shadow_count < TABLE_SIZE)
                    begin
                        shadow_count++;
                    end
                    rs.placed = 1'b1;
                    rs.rank   = pos[RANK_W-1:0];
                end
            end
            REQ_READ:
            begin
                if (int'(rq.idx) < shadow_count)
                begin
                    rs.row_valid = 1'b1;
                    rs.score     = shadow_rows[rq.idx].score;
                    rs.depth     = shadow_rows[rq.idx].depth;
                    rs.turns     = shadow_rows[rq.idx].turns;
                    rs.handle    = shadow_rows[rq.idx].handle;
                end
            end
            REQ_CLEAR:
            begin
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        rs.count = shadow_count[ECNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_request(input logic [1:0] req, input logic [31:0] score,
                               input logic [7:0] depth, input logic [31:0] turns,
                               input logic [15:0] handle, input logic [3:0] idx);
        request_t rq;
        rq.req    = req;
        rq.score  = score;
        rq.depth  = depth;
        rq.turns  = turns;
        rq.handle = handle;
        rq.idx    = idx;
        pending_q = {pending_q, rq};
        total_requests++;
    endtask

    function automatic logic [31:0] pick_key(input int width);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 7);
            4:          v = 32'd0;
            5:          v = mask;
            default:    v = $urandom;
        endcase
        return v & mask;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rank_request(cur_req, want);
                response_q = {response_q, want};
                accepted_requests++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() != 0 && !take_idle())
                begin
                    cur_req = pending_q.pop_front();
                    s_tdata <= {4'b0, cur_req.idx, cur_req.handle, cur_req.turns,
                                cur_req.depth, cur_req.score};
                    s_tuser <= cur_req.req;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.placed    = m_tuser[0];
                got.row_valid = m_tuser[1];
                got.rank      = m_tdata[RANK_W-1:0];
                got.score     = m_tdata[OFS_SCORE +: SCORE_W];
                got.depth     = m_tdata[OFS_DEPTH +: DEPTH_W];
                got.turns     = m_tdata[OFS_TURNS +: TURNS_W];
                got.handle    = m_tdata[OFS_HANDLE +: HANDLE_W];
                got.count     = m_tdata[OFS_COUNT +: ECNT_W];
                if (response_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = response_q.pop_front();
                    check_field("placed", 32'(want.placed), 32'(got.placed));
                    check_field("rank", 32'(want.rank), 32'(got.rank));
                    check_field("row_valid", 32'(want.row_valid), 32'(got.row_valid));
                    check_field("row_score", want.score, got.score);
                    check_field("row_depth", 32'(want.depth), 32'(got.depth));
                    check_field("row_turns", want.turns, got.turns);
                    check_field("row_handle", 32'(want.handle), 32'(got.handle));
                    check_field("entry_count", 32'(want.count), 32'(got.count));
                end
            end
            m_tready <= !take_idle();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("top_k_ranked_insert verification failed");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        logic [1:0]  req;

        // Directed part: empty table, unknown request, key extremes and ties.
        add_request(REQ_READ, '0, '0, '0, '0, 4'd0);
        add_request(REQ_CLEAR, '0, '0, '0, '0, 4'd0);
        add_request(REQ_UNKNOWN, '1, '1, '1, '1, 4'hF);
        add_request(REQ_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'd0, 16'hFFFF, 4'd0);
        add_request(REQ_INSERT, 32'd0, 8'd0, 32'hFFFF_FFFF, 16'h0000, 4'd0);
        add_request(REQ_INSERT, 32'd100, 8'd5, 32'd10, 16'd1, 4'd0);
        add_request(REQ_INSERT, 32'd100, 8'd5, 32'd10, 16'd2, 4'd0);
        add_request(REQ_INSERT, 32'd100, 8'd5, 32'd9, 16'd3, 4'd0);
        add_request(REQ_INSERT, 32'd100, 8'd6, 32'd50, 16'd4, 4'd0);
        add_request(REQ_INSERT, 32'd100, 8'd4, 32'd0, 16'd5, 4'd0);
        for (int i = 0; i < 8; i++)
        begin
            add_request(REQ_READ, '0, '0, '0, '0, i[3:0]);
        end
        add_request(REQ_READ, '0, '0, '0, '0, 4'd15);
        add_request(REQ_CLEAR, '0, '0, '0, '0, 4'd0);
        add_request(REQ_READ, '0, '0, '0, '0, 4'd0);
        add_request(REQ_INSERT, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF, 16'h8000, 4'd0);
        add_request(REQ_READ, '0, '0, '0, '0, 4'd0);

        // Random part: mostly inserts and reads so the table fills, ties and
        // rejections occur, with occasional clears and unknown requests.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
            begin
                req = REQ_INSERT;
            end
            else if (pick < 94)
            begin
                req = REQ_READ;
            end
            else if (pick < 97)
            begin
                req = REQ_CLEAR;
            end
            else
            begin
                req = REQ_UNKNOWN;
            end
            add_request(req, pick_key(SCORE_W), pick_key(DEPTH_W), pick_key(TURNS_W),
                        16'($urandom), 4'($urandom_range(0, 15)));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_requests != total_requests || response_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0)
        begin
            $display("top_k_ranked_insert verification clean");
        end
        else
        begin
            $display("top_k_ranked_insert verification failed");
        end
        $finish;
    end

endmodule
